[rtl/rcpsn_pkg.sv]
// Package for the ring cross-product surface normal block.
// Default sizes and the reset value of the depth threshold register.
// No dependencies.
package rcpsn_pkg;

  localparam int MAX_RING_DEF   = 64;
  localparam int COORD_BITS_DEF = 32;
  localparam logic [31:0] THRESH_RESET = 32'd13107;
  localparam int COUNT_MAX = 127;

endpackage

[rtl/ring_cross_product_surface_normal.sv]
// Ring cross-product surface normal: accumulation, normalization and plane offset.
// Depends on rcpsn_pkg.
//
// Usage:
//  A transaction is accepted when start is high and busy is low. A pixel is a
//  centre transaction (command 0) followed by its ring neighbours (command 1).
//  The transaction marked last produces one result, shown for one cycle with
//  done high. The receiver cannot stall; a result must be taken when done is high.
//  depth_threshold is written when depth_threshold_we is high; the user must do
//  that only while idle, as the block does not enforce it. A centre item, a
//  dropped neighbour or the first kept neighbour leaves the block idle unless it
//  is marked last. A later kept neighbour keeps busy high while the shared
//  multiplier forms the six cross products. After the last item come the closing
//  cross product, normalization (one bit shift per cycle), sum of squares, square
//  root, six restoring divisions in a bit-serial divider, the centroid dot product
//  and output. A degenerate pixel skips the steps after the closing cross product.
//  Reset (rst, synchronous) clears the state machine, done and the pixel sums, and sets the threshold to 13107.
module ring_cross_product_surface_normal
  import rcpsn_pkg::*;
#(
  parameter int MAX_RING   = MAX_RING_DEF,
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  logic                         command,
  input  logic signed [COORD_BITS-1:0] point_x,
  input  logic signed [COORD_BITS-1:0] point_y,
  input  logic signed [COORD_BITS-1:0] point_z,
  input  logic                         at_border,
  input  logic                         last,
  input  logic                         depth_threshold_we,
  input  logic        [31:0]           depth_threshold,
  output logic                         done,
  output logic signed [31:0]           unit_x,
  output logic signed [31:0]           unit_y,
  output logic        [30:0]           unit_z,
  output logic signed [31:0]           plane_offset,
  output logic                         degenerate
);

  localparam int DW   = COORD_BITS + 1;
  localparam int MW   = (DW > 33) ? DW : 33;
  localparam int PW   = 2 * MW;
  localparam int TW   = PW + 1 - 16;
  localparam int EW   = (TW > 56) ? TW : 56;
  localparam int SW   = EW + 1;
  localparam int CSW  = ((COORD_BITS > 40) ? COORD_BITS : 40) + 2;
  localparam int TCW  = (DW > 32) ? DW : 32;
  localparam int KEEP_LIMIT = (MAX_RING < COUNT_MAX) ? MAX_RING : COUNT_MAX;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_CROSS = 4'd1;
  localparam logic [3:0] S_FIN   = 4'd2;
  localparam logic [3:0] S_CHECK = 4'd3;
  localparam logic [3:0] S_NORM  = 4'd4;
  localparam logic [3:0] S_SQ    = 4'd5;
  localparam logic [3:0] S_SQRT  = 4'd6;
  localparam logic [3:0] S_DLOAD = 4'd7;
  localparam logic [3:0] S_DIV   = 4'd8;
  localparam logic [3:0] S_DOT   = 4'd9;
  localparam logic [3:0] S_OUT   = 4'd10;

  logic [3:0]  state;
  logic [5:0]  step;
  logic [31:0] thresh;
  logic signed [COORD_BITS-1:0] cz [3];
  logic        border;
  logic signed [DW-1:0] first_d [3];
  logic signed [DW-1:0] prev_d [3];
  logic signed [DW-1:0] ua [3];
  logic signed [DW-1:0] ub [3];
  logic signed [55:0] cs [3];
  logic signed [39:0] cent [3];
  logic [6:0]  kept;
  logic        last_pend;
  logic        closing;
  logic        flip;
  logic [55:0] mv [3];
  logic signed [PW-1:0] preg;
  logic signed [PW:0]   wacc;
  logic [63:0] sq;
  logic [63:0] sx;
  logic [63:0] res;
  logic [63:0] bitv;
  logic [31:0] lenr;
  logic [2:0]  didx;
  logic [61:0] num;
  logic [31:0] den;
  logic [32:0] rem;
  logic [61:0] quo;
  logic signed [31:0] nv [3];
  logic signed [31:0] cv [3];
  logic signed [63:0] dot;

  // shared multiplier operands
  logic signed [MW-1:0] mul_a, mul_b;
  logic [1:0] mi;

  always_comb begin
    mi = step[1:0];
    mul_a = '0;
    mul_b = '0;
    unique case (state)
      S_CROSS: begin
        unique case (step[2:0])
          3'd0: begin mul_a = MW'(ua[1]); mul_b = MW'(ub[2]); end
          3'd1: begin mul_a = MW'(ua[2]); mul_b = MW'(ub[1]); end
          3'd2: begin mul_a = MW'(ua[2]); mul_b = MW'(ub[0]); end
          3'd3: begin mul_a = MW'(ua[0]); mul_b = MW'(ub[2]); end
          3'd4: begin mul_a = MW'(ua[0]); mul_b = MW'(ub[1]); end
          3'd5: begin mul_a = MW'(ua[1]); mul_b = MW'(ub[0]); end
          default: begin mul_a = '0; mul_b = '0; end
        endcase
      end
      S_SQ: begin
        if (mi != 2'd3) begin
          mul_a = MW'({1'b0, mv[mi][30:0]});
          mul_b = MW'({1'b0, mv[mi][30:0]});
        end
      end
      S_DOT: begin
        if (mi != 2'd3) begin
          mul_a = MW'(cv[mi]);
          mul_b = MW'(nv[mi]);
        end
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // input side
  logic signed [COORD_BITS-1:0] pin [3];
  logic signed [DW-1:0] dl [3];
  logic [DW-1:0] adz;
  logic keep;
  logic signed [CSW-1:0] csum [3];
  logic signed [39:0] csat [3];

  always_comb begin
    pin[0] = point_x;
    pin[1] = point_y;
    pin[2] = point_z;
    for (int k = 0; k < 3; k++) begin
      dl[k] = DW'(pin[k]) - DW'(cz[k]);
      csum[k] = CSW'(cent[k]) + CSW'(pin[k]);
      if (csum[k][CSW-1:39] == '0 || csum[k][CSW-1:39] == '1)
        csat[k] = csum[k][39:0];
      else
        csat[k] = csum[k][CSW-1] ? {1'b1, 39'd0} : {1'b0, {39{1'b1}}};
    end
    adz = dl[2][DW-1] ? DW'(-dl[2]) : DW'(dl[2]);
    keep = (TCW'(adz) < TCW'(thresh)) && (kept < 7'(KEEP_LIMIT));
  end

  // cross term: difference of products, floor shift, saturating accumulate
  logic signed [PW:0]   term_full;
  logic signed [TW-1:0] term_sh;
  logic signed [SW-1:0] xsum;
  logic signed [55:0]   xsat;
  logic [1:0] ti;

  always_comb begin
    term_full = wacc - (PW+1)'(preg);
    term_sh = term_full[PW:16];
    unique case (step[2:0])
      3'd2: ti = 2'd0;
      3'd4: ti = 2'd1;
      default: ti = 2'd2;
    endcase
    xsum = SW'(term_sh) + SW'(cs[ti]);
    if (xsum[SW-1:55] == '0 || xsum[SW-1:55] == '1)
      xsat = xsum[55:0];
    else
      xsat = xsum[SW-1] ? {1'b1, 55'd0} : {1'b0, {55{1'b1}}};
  end

  // normalize, square root, divide
  logic [55:0] mx;
  logic [63:0] trial;
  logic [63:0] res_n;
  logic [32:0] rem_sh;
  logic        ge;
  logic [32:0] rem_n;
  logic [61:0] quo_n;
  logic [1:0]  ck;
  logic [31:0] qclamp;
  logic signed [31:0] cval;

  always_comb begin
    mx = mv[0];
    if (mv[1] > mx) mx = mv[1];
    if (mv[2] > mx) mx = mv[2];
    trial = res + bitv;
    res_n = (sx >= trial) ? ((res >> 1) + bitv) : (res >> 1);
    rem_sh = {rem[31:0], num[61]};
    ge = rem_sh >= {1'b0, den};
    rem_n = ge ? (rem_sh - {1'b0, den}) : rem_sh;
    quo_n = {quo[60:0], ge};
    ck = (didx < 3'd3) ? didx[1:0] : 2'(didx - 3'd3);
    qclamp = (quo_n > 62'h40000000) ? 32'h40000000 : quo_n[31:0];
    if (cent[ck][39])
      cval = (quo_n > 62'h80000000) ? 32'sh80000000 : 32'(-quo_n[31:0]);
    else
      cval = (quo_n > 62'h7FFFFFFF) ? 32'sh7FFFFFFF : quo_n[31:0];
  end

  // plane offset
  logic [63:0] dmag;
  logic [63:0] rnd;
  logic [33:0] rr;
  logic signed [31:0] dval;

  always_comb begin
    dmag = dot[63] ? 64'(-dot) : 64'(dot);
    rnd = (dmag + 64'h20000000) >> 30;
    rr = (rnd > 64'h100000000) ? 34'h100000000 : rnd[33:0];
    if (dot[63])
      dval = (rr > 34'h7FFFFFFF) ? 32'sh7FFFFFFF : rr[31:0];
    else
      dval = (rr > 34'h80000000) ? 32'sh80000000 : 32'(-rr[31:0]);
  end

  logic degen;
  assign degen = border || kept == '0 || (cs[0] == '0 && cs[1] == '0 && cs[2] == '0);

  assign busy = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      step <= '0;
      thresh <= THRESH_RESET;
      border <= 1'b0;
      kept <= '0;
      last_pend <= 1'b0;
      closing <= 1'b0;
      done <= 1'b0;
      for (int k = 0; k < 3; k++) begin
        cz[k] <= '0;
        first_d[k] <= '0;
        prev_d[k] <= '0;
        cs[k] <= '0;
        cent[k] <= '0;
      end
    end else begin
      done <= (state == S_OUT) || (state == S_CHECK && degen);
      if (depth_threshold_we)
        thresh <= depth_threshold;
      preg <= mul_a * mul_b;
      unique case (state)
        S_IDLE: begin
          if (start) begin
            last_pend <= last;
            if (!command) begin
              for (int k = 0; k < 3; k++) begin
                cz[k] <= pin[k];
                first_d[k] <= '0;
                prev_d[k] <= '0;
                cs[k] <= '0;
                cent[k] <= '0;
              end
              border <= at_border;
              kept <= '0;
              if (last) state <= S_FIN;
            end else if (keep) begin
              kept <= kept + 7'd1;
              for (int k = 0; k < 3; k++) begin
                cent[k] <= csat[k];
                prev_d[k] <= dl[k];
              end
              if (kept == '0) begin
                for (int k = 0; k < 3; k++) first_d[k] <= dl[k];
                if (last) state <= S_FIN;
              end else begin
                for (int k = 0; k < 3; k++) begin
                  ua[k] <= prev_d[k];
                  ub[k] <= dl[k];
                end
                step <= '0;
                state <= S_CROSS;
              end
            end else if (last) begin
              state <= S_FIN;
            end
          end
        end
        S_CROSS: begin
          step <= step + 6'd1;
          if (step != '0) begin
            if (step[0])
              wacc <= (PW+1)'(preg);
            else
              cs[ti] <= xsat;
          end
          if (step == 6'd6)
            state <= closing ? S_CHECK : (last_pend ? S_FIN : S_IDLE);
        end
        S_FIN: begin
          if (kept != '0) begin
            for (int k = 0; k < 3; k++) begin
              ua[k] <= prev_d[k];
              ub[k] <= first_d[k];
            end
            closing <= 1'b1;
            step <= '0;
            state <= S_CROSS;
          end else begin
            state <= S_CHECK;
          end
        end
        S_CHECK: begin
          closing <= 1'b0;
          if (degen) begin
            unit_x <= '0;
            unit_y <= '0;
            unit_z <= '0;
            plane_offset <= '0;
            degenerate <= 1'b1;
            kept <= '0;
            for (int k = 0; k < 3; k++) begin
              first_d[k] <= '0;
              prev_d[k] <= '0;
              cs[k] <= '0;
              cent[k] <= '0;
            end
            state <= S_IDLE;
          end else begin
            for (int k = 0; k < 3; k++)
              mv[k] <= cs[k][55] ? 56'(-cs[k]) : 56'(cs[k]);
            flip <= cs[2][55];
            state <= S_NORM;
          end
        end
        S_NORM: begin
          if (mx[55:30] == '0) begin
            for (int k = 0; k < 3; k++) mv[k] <= mv[k] << 1;
          end else if (mx[55:31] != '0) begin
            for (int k = 0; k < 3; k++) mv[k] <= mv[k] >> 1;
          end else begin
            sq <= '0;
            step <= '0;
            state <= S_SQ;
          end
        end
        S_SQ: begin
          if (step != '0) sq <= sq + preg[63:0];
          if (step == 6'd3) begin
            sx <= sq + preg[63:0];
            res <= '0;
            bitv <= 64'd1 << 62;
            step <= '0;
            state <= S_SQRT;
          end else begin
            step <= step + 6'd1;
          end
        end
        S_SQRT: begin
          step <= step + 6'd1;
          if (sx >= trial) sx <= sx - trial;
          res <= res_n;
          bitv <= bitv >> 2;
          if (step == 6'd31) begin
            lenr <= res_n[31:0];
            didx <= '0;
            state <= S_DLOAD;
          end
        end
        S_DLOAD: begin
          if (didx < 3'd3) begin
            num <= (62'(mv[ck][30:0]) << 30) + 62'(lenr >> 1);
            den <= lenr;
          end else begin
            num <= cent[ck][39] ? 62'(-cent[ck]) : 62'(cent[ck]);
            den <= 32'(kept);
          end
          rem <= '0;
          quo <= '0;
          step <= '0;
          state <= S_DIV;
        end
        S_DIV: begin
          rem <= rem_n;
          quo <= quo_n;
          num <= num << 1;
          if (step == 6'd61) begin
            if (didx < 3'd3)
              nv[ck] <= (cs[ck][55] ^ flip) ? -qclamp : qclamp;
            else
              cv[ck] <= cval;
            if (didx == 3'd5) begin
              dot <= '0;
              step <= '0;
              state <= S_DOT;
            end else begin
              didx <= didx + 3'd1;
              state <= S_DLOAD;
            end
          end else begin
            step <= step + 6'd1;
          end
        end
        S_DOT: begin
          step <= step + 6'd1;
          if (step != '0) dot <= dot + preg[63:0];
          if (step == 6'd3) state <= S_OUT;
        end
        S_OUT: begin
          unit_x <= nv[0];
          unit_y <= nv[1];
          unit_z <= nv[2][30:0];
          plane_offset <= dval;
          degenerate <= 1'b0;
          kept <= '0;
          for (int k = 0; k < 3; k++) begin
            first_d[k] <= '0;
            prev_d[k] <= '0;
            cs[k] <= '0;
            cent[k] <= '0;
          end
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

[tb/rcpsn_checker.sv]
// Checker for ring_cross_product_surface_normal: watches the command and result ports,
// predicts each normal and plane offset, and compares them field by field.
// Depends on rcpsn_pkg.
module rcpsn_checker
  import rcpsn_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic               busy,
  input  logic               command,
  input  logic signed [31:0] point_x,
  input  logic signed [31:0] point_y,
  input  logic signed [31:0] point_z,
  input  logic               at_border,
  input  logic               last,
  input  logic               depth_threshold_we,
  input  logic        [31:0] depth_threshold,
  input  logic               done,
  input  logic signed [31:0] unit_x,
  input  logic signed [31:0] unit_y,
  input  logic        [30:0] unit_z,
  input  logic signed [31:0] plane_offset,
  input  logic               degenerate,
  output int                 errors,
  output int                 pending
);

  localparam int KEEP_LIMIT = (MAX_RING_DEF < COUNT_MAX) ? MAX_RING_DEF : COUNT_MAX;
  localparam logic signed [127:0] XMAX = 128'sd36028797018963967;
  localparam logic signed [127:0] XMIN = -128'sd36028797018963968;
  localparam logic signed [63:0] CMAX = 64'sd549755813887;
  localparam logic signed [63:0] CMIN = -64'sd549755813888;

  typedef struct packed {
    logic signed [31:0] nx;
    logic signed [31:0] ny;
    logic        [30:0] nz;
    logic signed [31:0] off;
    logic               deg;
  } normal_t;

  normal_t            normal_q[$];
  logic        [31:0] thresh;
  logic signed [31:0] centre[3];
  logic signed [32:0] first_d[3];
  logic signed [32:0] prev_d[3];
  logic signed [55:0] xsum[3];
  logic signed [39:0] csum[3];
  int                 kept;
  bit                 border;

  assign pending = normal_q.size();

  function automatic logic signed [55:0] cross_term(logic signed [32:0] a, logic signed [32:0] b,
                                                    logic signed [32:0] c, logic signed [32:0] d);
    logic signed [127:0] w;
    w = a;
    w = w * b;
    w = w - 128'(c) * 128'(d);
    w = w >>> 16;
    if (w > XMAX) w = XMAX;
    if (w < XMIN) w = XMIN;
    return w[55:0];
  endfunction

  function automatic logic [63:0] int_sqrt(logic [63:0] x);
    logic [63:0] res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > x) bitv >>= 2;
    while (bitv != 0) begin
      if (x >= res + bitv) begin
        x -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  task automatic accumulate_cross(logic signed [32:0] a[3], logic signed [32:0] b[3]);
    logic signed [55:0] t[3];
    logic signed [57:0] s;
    t[0] = cross_term(a[1], b[2], a[2], b[1]);
    t[1] = cross_term(a[2], b[0], a[0], b[2]);
    t[2] = cross_term(a[0], b[1], a[1], b[0]);
    for (int k = 0; k < 3; k++) begin
      s = 58'(xsum[k]) + 58'(t[k]);
      if (s > 58'(XMAX)) s = 58'(XMAX);
      if (s < 58'(XMIN)) s = 58'(XMIN);
      xsum[k] = s[55:0];
    end
  endtask

  task automatic clear_sums();
    for (int k = 0; k < 3; k++) begin
      first_d[k] = '0;
      prev_d[k] = '0;
      xsum[k] = '0;
      csum[k] = '0;
    end
    kept = 0;
  endtask

  task automatic finish_pixel(output normal_t r);
    logic [63:0] m[3], mx, sq, len, q, cm, rr;
    longint n[3], c, dot, d, cs;
    bit flip;
    if (kept > 0) accumulate_cross(prev_d, first_d);
    r = '0;
    if (border || kept == 0 || (xsum[0] == 0 && xsum[1] == 0 && xsum[2] == 0)) begin
      r.deg = 1'b1;
      return;
    end
    mx = 0;
    for (int k = 0; k < 3; k++) begin
      m[k] = xsum[k] < 0 ? 64'(-longint'(xsum[k])) : 64'(xsum[k]);
      if (m[k] > mx) mx = m[k];
    end
    while (mx < (64'd1 << 30)) begin
      mx <<= 1;
      for (int k = 0; k < 3; k++) m[k] <<= 1;
    end
    while (mx >= (64'd1 << 31)) begin
      mx >>= 1;
      for (int k = 0; k < 3; k++) m[k] >>= 1;
    end
    sq = m[0] * m[0] + m[1] * m[1] + m[2] * m[2];
    len = int_sqrt(sq);
    if (len == 0) len = 1;
    flip = xsum[2] < 0;
    for (int k = 0; k < 3; k++) begin
      q = ((m[k] << 30) + (len >> 1)) / len;
      if (q > (64'd1 << 30)) q = 64'd1 << 30;
      n[k] = ((xsum[k] < 0) != flip) ? -longint'(q) : longint'(q);
    end
    dot = 0;
    for (int k = 0; k < 3; k++) begin
      cs = csum[k];
      cm = (cs < 0 ? 64'(-cs) : 64'(cs)) / 64'(kept);
      c = cs < 0 ? -longint'(cm) : longint'(cm);
      if (c > 64'sd2147483647) c = 64'sd2147483647;
      if (c < -64'sd2147483648) c = -64'sd2147483648;
      dot += c * n[k];
    end
    rr = ((dot < 0 ? 64'(-dot) : 64'(dot)) + (64'd1 << 29)) >> 30;
    if (rr > (64'd1 << 32)) rr = 64'd1 << 32;
    d = dot < 0 ? longint'(rr) : -longint'(rr);
    if (d > 64'sd2147483647) d = 64'sd2147483647;
    if (d < -64'sd2147483648) d = -64'sd2147483648;
    r.nx = n[0][31:0];
    r.ny = n[1][31:0];
    r.nz = n[2][30:0];
    r.off = d[31:0];
  endtask

  task automatic predict_transaction();
    logic signed [31:0] p[3];
    logic signed [32:0] dl[3];
    logic signed [32:0] dz;
    logic        [32:0] diff;
    logic signed [40:0] s;
    normal_t            r;
    p[0] = point_x;
    p[1] = point_y;
    p[2] = point_z;
    if (!command) begin
      for (int k = 0; k < 3; k++) centre[k] = p[k];
      border = at_border;
      clear_sums();
    end else begin
      dz = 33'(p[2]) - 33'(centre[2]);
      diff = dz < 0 ? -dz : dz;
      if (diff < 33'(thresh) && kept < KEEP_LIMIT) begin
        for (int k = 0; k < 3; k++) dl[k] = 33'(p[k]) - 33'(centre[k]);
        if (kept == 0) for (int k = 0; k < 3; k++) first_d[k] = dl[k];
        else accumulate_cross(prev_d, dl);
        for (int k = 0; k < 3; k++) begin
          prev_d[k] = dl[k];
          s = 41'(csum[k]) + 41'(p[k]);
          if (s > 41'(CMAX)) s = 41'(CMAX);
          if (s < 41'(CMIN)) s = 41'(CMIN);
          csum[k] = s[39:0];
        end
        kept++;
      end
    end
    if (last) begin
      finish_pixel(r);
      clear_sums();
      normal_q = {normal_q, r};
    end
  endtask

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $time);
    errors++;
  endtask

  initial errors = 0;

  always @(posedge clk) begin
    normal_t w;
    if (rst) begin
      thresh = THRESH_RESET;
      for (int k = 0; k < 3; k++) centre[k] = '0;
      border = 1'b0;
      clear_sums();
      normal_q.delete();
    end else begin
      if (done) begin
        if (normal_q.size() == 0) begin
          report_mismatch("unexpected result", 0, 0);
        end else begin
          w = normal_q.pop_front();
          if (unit_x !== w.nx) report_mismatch("unit_x", unit_x, w.nx);
          if (unit_y !== w.ny) report_mismatch("unit_y", unit_y, w.ny);
          if (unit_z !== w.nz) report_mismatch("unit_z", unit_z, w.nz);
          if (plane_offset !== w.off) report_mismatch("plane_offset", plane_offset, w.off);
          if (degenerate !== w.deg) report_mismatch("degenerate", degenerate, w.deg);
        end
      end
      if (start && !busy) predict_transaction();
      if (depth_threshold_we) thresh = depth_threshold;
    end
  end

endmodule

[tb/tb_ring_cross_product_surface_normal.sv]
// Testbench top for ring_cross_product_surface_normal: drives directed and random pixels
// under several depth thresholds, and gives the verdict from rcpsn_checker.
// Depends on rcpsn_pkg, rcpsn_checker and the block itself.
module tb_ring_cross_product_surface_normal
  import rcpsn_pkg::*;
();

  localparam int STALL_LIMIT = 20000;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               start = 1'b0;
  logic               busy;
  logic               command = 1'b0;
  logic signed [31:0] point_x = '0;
  logic signed [31:0] point_y = '0;
  logic signed [31:0] point_z = '0;
  logic               at_border = 1'b0;
  logic               last = 1'b0;
  logic               depth_threshold_we = 1'b0;
  logic        [31:0] depth_threshold = '0;
  logic               done;
  logic signed [31:0] unit_x;
  logic signed [31:0] unit_y;
  logic        [30:0] unit_z;
  logic signed [31:0] plane_offset;
  logic               degenerate;
  int                 errors;
  int                 pending;
  int                 stall_cnt = 0;
  int                 sent = 0;
  bit                 calm = 0;
  logic        [31:0] cur_thresh = THRESH_RESET;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  ring_cross_product_surface_normal i_dut (
    .clk, .rst, .start, .busy, .command, .point_x, .point_y, .point_z, .at_border, .last,
    .depth_threshold_we, .depth_threshold, .done, .unit_x, .unit_y, .unit_z,
    .plane_offset, .degenerate
  );

  rcpsn_checker i_checker (
    .clk, .rst, .start, .busy, .command, .point_x, .point_y, .point_z, .at_border, .last,
    .depth_threshold_we, .depth_threshold, .done, .unit_x, .unit_y, .unit_z,
    .plane_offset, .degenerate, .errors, .pending
  );

  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      stall_cnt <= 0;
    end else begin
      stall_cnt <= stall_cnt + 1;
      if (stall_cnt >= STALL_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  // called at a falling edge; returns at the falling edge after acceptance
  task automatic send(logic cmd, logic signed [31:0] x, logic signed [31:0] y,
                      logic signed [31:0] z, logic brd, logic lst);
    if (!calm) begin
      while ($urandom_range(99) < 35) begin
        start = 1'b0;
        @(negedge clk);
      end
    end
    command = cmd;
    point_x = x;
    point_y = y;
    point_z = z;
    at_border = brd;
    last = lst;
    start = 1'b1;
    while (busy) @(negedge clk);
    @(negedge clk);
    sent++;
  endtask

  task automatic write_threshold(logic [31:0] v);
    start = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (600) @(negedge clk);
    depth_threshold = v;
    depth_threshold_we = 1'b1;
    @(negedge clk);
    depth_threshold_we = 1'b0;
    cur_thresh = v;
  endtask

  function automatic logic signed [31:0] near(logic signed [31:0] c, int span);
    return c + $signed(32'($urandom_range(2 * span))) - span;
  endfunction

  task automatic random_pixel();
    logic signed [31:0] cx, cy, cz, dz;
    int n, zspan;
    bit wide;
    wide = $urandom_range(9) == 0;
    cx = wide ? $urandom : near(0, 1 << 20);
    cy = wide ? $urandom : near(0, 1 << 20);
    cz = wide ? $urandom : near(0, 1 << 19);
    n = $urandom_range(19) == 0 ? $urandom_range(70, 60) : $urandom_range(12, 1);
    send(1'b0, cx, cy, cz, $urandom_range(7) == 0, n == 0);
    zspan = (cur_thresh > 32'h4000_0000 || cur_thresh == 0) ? 1 << 18 : int'(cur_thresh) + 2;
    for (int i = 0; i < n; i++) begin
      dz = $urandom_range(9) == 0 ? $urandom : near(0, zspan);
      send(1'b1, wide ? $urandom : near(cx, 1 << 18), wide ? $urandom : near(cy, 1 << 18),
           cz + dz, $urandom_range(1), i == n - 1);
    end
  endtask

  task automatic noise_item();
    send($urandom_range(1), $urandom, $urandom, $urandom, $urandom_range(1),
         $urandom_range(3) == 0);
  endtask

  initial begin
    logic [31:0] thr_set[4];
    thr_set[0] = 32'hFFFF_FFFF;
    thr_set[1] = 32'h0000_0000;
    thr_set[2] = 32'd65536;
    thr_set[3] = $urandom_range(32'h0002_0000, 1);
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // neighbour before any centre, then last on a centre item
    send(1'b1, 32'sd65536, 32'sd0, 32'sd100, 1'b0, 1'b0);
    send(1'b1, 32'sd0, 32'sd65536, 32'sd200, 1'b0, 1'b1);
    send(1'b0, 32'sd0, 32'sd0, 32'sd0, 1'b0, 1'b1);
    // nearly flat square ring, a border pixel, a collinear ring
    send(1'b0, 32'sd0, 32'sd0, 32'sd65536, 1'b0, 1'b0);
    send(1'b1, 32'sd65536, 32'sd0, 32'sd65536, 1'b0, 1'b0);
    send(1'b1, 32'sd0, 32'sd65536, 32'sd65636, 1'b0, 1'b0);
    send(1'b1, -32'sd65536, 32'sd0, 32'sd65536, 1'b0, 1'b0);
    send(1'b1, 32'sd0, -32'sd65536, 32'sd65536, 1'b0, 1'b1);
    send(1'b0, 32'sd0, 32'sd0, 32'sd0, 1'b1, 1'b0);
    send(1'b1, 32'sd65536, 32'sd0, 32'sd0, 1'b0, 1'b0);
    send(1'b1, 32'sd0, 32'sd65536, 32'sd0, 1'b0, 1'b1);
    send(1'b0, 32'sd0, 32'sd0, 32'sd0, 1'b0, 1'b0);
    send(1'b1, 32'sd65536, 32'sd65536, 32'sd0, 1'b0, 1'b0);
    send(1'b1, 32'sd131072, 32'sd131072, 32'sd0, 1'b0, 1'b1);

    // extreme coordinates under the widest depth threshold
    write_threshold(thr_set[0]);
    send(1'b0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0, 1'b0);
    send(1'b1, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 1'b0, 1'b0);
    send(1'b1, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0, 1'b0);
    send(1'b1, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 1'b0, 1'b1);
    send(1'b0, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b0, 1'b0);
    send(1'b1, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0, 1'b0);
    send(1'b1, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 1'b0, 1'b0);
    send(1'b1, 32'hFFFF_FFFF, 32'h0000_0001, 32'h7FFF_FFFF, 1'b1, 1'b1);

    for (int ph = 0; ph < 5; ph++) begin
      if (ph > 0) write_threshold(thr_set[ph - 1]);
      while (sent < 40 + (ph + 1) * 280) begin
        calm = (ph == 2);
        if ($urandom_range(9) == 0) noise_item();
        else random_pixel();
      end
    end
    calm = 0;
    write_threshold(THRESH_RESET);
    random_pixel();

    start = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (600) @(negedge clk);
    if (errors == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule
